// File: src/shspi_pkg.sv
// Shared types and constants for the sensor hub SPI transfer engine.
// Used by the front queue, the back engine, the top level and the checker.
package shspi_pkg;

  // Buffer sizes and header framing
  localparam int RX_BYTES     = 512;
  localparam int TX_BYTES     = 256;
  localparam int HEADER_BYTES = 4;
  localparam int RX_AW        = $clog2(RX_BYTES);
  localparam int TX_AW        = $clog2(TX_BYTES);
  localparam int CNT_W        = 10;
  localparam int FILL_W       = 9;
  localparam logic [15:0] LEN_FLAG = 16'h8000;

  typedef enum logic [1:0] {
    ACT_IRQ  = 2'd0,
    ACT_LOAD = 2'd1,
    ACT_XFER = 2'd2,
    ACT_POP  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HDR   = 2'd1,
    PH_BODY  = 2'd2,
    PH_WRITE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BUSY      = 3'd1,
    ST_BAD_PARAM = 3'd2,
    ST_NONE      = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  // One classified event as it travels from front to back
  typedef struct packed {
    act_t        act;
    logic [7:0]  miso_byte;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] read_capacity;
    logic [31:0] event_time_us;
  } item_t;

endpackage

// File: src/shspi_front.sv
// Front part: accepts input items, classifies the action and queues them.
// Depends on shspi_pkg for item_t and act_t.
module shspi_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [7:0]          miso_byte,
  input  logic [7:0]          tx_byte,
  input  logic                tx_last,
  input  logic [15:0]         read_capacity,
  input  logic [31:0]         event_time_us,
  output logic                q_valid,
  input  logic                q_take,
  output shspi_pkg::item_t    q_item
);
  import shspi_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      item_in;

  // Classify the incoming event
  always_comb begin
    item_in.act           = act_t'(action);
    item_in.miso_byte     = miso_byte;
    item_in.tx_byte       = tx_byte;
    item_in.tx_last       = tx_last;
    item_in.read_capacity = read_capacity;
    item_in.event_time_us = event_time_us;
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = q[rd_ptr];

  // Hold queued payload
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/shspi_back.sv
// Back part: link state machine, receive and transmit stores, result register.
// Depends on shspi_pkg for item_t, phase_t, status_t and buffer constants.
module shspi_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                q_valid,
  output logic                q_take,
  input  shspi_pkg::item_t    q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                chip_select_n,
  output logic                wake_n,
  output logic                mosi_valid,
  output logic [7:0]          mosi_byte,
  output logic                rx_valid,
  output logic [7:0]          rx_out,
  output logic                rx_last,
  output logic [9:0]          msg_length,
  output logic [31:0]         stamp_us,
  output logic [2:0]          status
);
  import shspi_pkg::*;

  // Link state
  logic              enable;
  phase_t            phase, phase_next;
  logic              pending, pending_next;
  logic [CNT_W-1:0]  rx_count, rx_count_next;
  logic [FILL_W-1:0] tx_fill, tx_fill_next;
  logic [FILL_W-1:0] tx_committed, tx_committed_next;
  logic [CNT_W-1:0]  byte_index, byte_index_next;
  logic [CNT_W-1:0]  expected_len, expected_len_next;
  logic [CNT_W-1:0]  read_index, read_index_next;
  logic [31:0]       latched_time, latched_time_next;
  logic              select_level, select_level_next;
  logic              wake_level, wake_level_next;
  logic              tx_overflow, tx_overflow_next;
  logic [7:0]        hdr0, hdr1;

  // Stores
  logic [7:0]        rx_mem [RX_BYTES];
  logic [7:0]        tx_mem [TX_BYTES];
  logic              rx_we, tx_we;
  logic [7:0]        rx_rd, tx_rd;

  // Per-item scratch
  status_t           status_c;
  logic              rxv_c, rxl_c, len_old_c, mosi_sel_c;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  rd_inc;
  logic [FILL_W-1:0] fill_inc;
  logic [7:0]        b0, b1;
  logic [15:0]       raw_len;
  logic [CNT_W-1:0]  hdr_len;
  logic [CNT_W-1:0]  commit_ext;

  // Result register
  status_t           status_r;
  logic              rxv_r, rxl_r, mosi_sel_r;
  logic [CNT_W-1:0]  len_r;
  logic              sel_r, wake_r, mvalid_r;
  logic [31:0]       stamp_r;

  assign q_take = q_valid && (!out_valid || out_ready);

  // Header length from bytes 0 and 1 of this transfer, missing bytes as zero
  always_comb begin
    idx_inc = byte_index + CNT_W'(1);
    b0      = (byte_index == '0) ? q_item.miso_byte : hdr0;
    if (idx_inc > CNT_W'(1)) begin
      b1 = (byte_index == CNT_W'(1)) ? q_item.miso_byte : hdr1;
    end else begin
      b1 = 8'd0;
    end
    raw_len = {b1, b0} & ~LEN_FLAG;
    hdr_len = (raw_len > 16'(RX_BYTES)) ? CNT_W'(RX_BYTES) : raw_len[CNT_W-1:0];
    commit_ext = CNT_W'(tx_committed);
    rd_inc     = read_index + CNT_W'(1);
    fill_inc   = tx_fill + FILL_W'(1);
  end

  // Next state and per-item results
  always_comb begin
    phase_next        = phase;
    pending_next      = pending;
    rx_count_next     = rx_count;
    tx_fill_next      = tx_fill;
    tx_committed_next = tx_committed;
    byte_index_next   = byte_index;
    expected_len_next = expected_len;
    read_index_next   = read_index;
    latched_time_next = latched_time;
    select_level_next = select_level;
    wake_level_next   = wake_level;
    tx_overflow_next  = tx_overflow;
    status_c          = ST_OK;
    rxv_c             = 1'b0;
    rxl_c             = 1'b0;
    len_old_c         = 1'b0;
    rx_we             = 1'b0;
    tx_we             = 1'b0;
    mosi_sel_c        = 1'b0;
    if (q_take) begin
      unique case (q_item.act)
        ACT_IRQ: begin
          latched_time_next = q_item.event_time_us;
          pending_next      = 1'b1;
        end
        ACT_LOAD: begin
          if (tx_committed != '0) begin
            status_c = ST_BUSY;
          end else if (tx_overflow || tx_fill >= FILL_W'(TX_BYTES)) begin
            status_c         = ST_BAD_PARAM;
            tx_overflow_next = !q_item.tx_last;
            if (q_item.tx_last) begin
              tx_fill_next = '0;
            end
          end else begin
            tx_we        = 1'b1;
            tx_fill_next = fill_inc;
            if (q_item.tx_last) begin
              tx_committed_next = fill_inc;
              tx_fill_next      = '0;
              wake_level_next   = 1'b0;
            end
          end
        end
        ACT_XFER: begin
          if (!enable || phase == PH_IDLE) begin
            status_c = ST_IGNORED;
          end else begin
            rx_we           = (byte_index < CNT_W'(RX_BYTES));
            byte_index_next = idx_inc;
            // End of transfer
            if (idx_inc >= expected_len) begin
              if (phase == PH_HDR && hdr_len > CNT_W'(HEADER_BYTES)) begin
                phase_next        = PH_BODY;
                expected_len_next = hdr_len;
              end else begin
                priority if (phase == PH_HDR) begin
                  rx_count_next = '0;
                end else if (phase == PH_BODY) begin
                  rx_count_next = hdr_len;
                end else begin
                  rx_count_next     = (commit_ext < hdr_len) ? commit_ext : hdr_len;
                  tx_committed_next = '0;
                end
                select_level_next = 1'b1;
                phase_next        = PH_IDLE;
                read_index_next   = '0;
              end
            end
          end
        end
        ACT_POP: begin
          len_old_c = 1'b1;
          if (rx_count == '0) begin
            status_c = ST_NONE;
          end else if (read_index == '0 && q_item.read_capacity < 16'(rx_count)) begin
            status_c      = ST_BAD_PARAM;
            rx_count_next = '0;
          end else begin
            rxv_c           = 1'b1;
            read_index_next = rd_inc;
            if (rd_inc >= rx_count) begin
              rxl_c           = 1'b1;
              rx_count_next   = '0;
              read_index_next = '0;
            end
          end
        end
        default: begin
          status_c = ST_OK;
        end
      endcase
      // Start a transfer once idle, drained and interrupted
      if (phase_next == PH_IDLE && rx_count_next == '0 && pending_next) begin
        pending_next      = 1'b0;
        select_level_next = 1'b0;
        byte_index_next   = '0;
        if (tx_committed_next != '0) begin
          phase_next        = PH_WRITE;
          expected_len_next = CNT_W'(tx_committed_next);
          wake_level_next   = 1'b1;
        end else begin
          phase_next        = PH_HDR;
          expected_len_next = CNT_W'(HEADER_BYTES);
        end
      end
      mosi_sel_c = (phase_next == PH_WRITE) && (byte_index_next < CNT_W'(TX_BYTES));
    end
  end

  // Link state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      phase        <= PH_IDLE;
      pending      <= 1'b0;
      rx_count     <= '0;
      tx_fill      <= '0;
      tx_committed <= '0;
      byte_index   <= '0;
      expected_len <= '0;
      read_index   <= '0;
      latched_time <= '0;
      select_level <= 1'b1;
      wake_level   <= 1'b1;
      tx_overflow  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        enable <= cfg_wdata;
      end
      phase        <= phase_next;
      pending      <= pending_next;
      rx_count     <= rx_count_next;
      tx_fill      <= tx_fill_next;
      tx_committed <= tx_committed_next;
      byte_index   <= byte_index_next;
      expected_len <= expected_len_next;
      read_index   <= read_index_next;
      latched_time <= latched_time_next;
      select_level <= select_level_next;
      wake_level   <= wake_level_next;
      tx_overflow  <= tx_overflow_next;
      if (q_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture header bytes as they arrive
  always_ff @(posedge clk) begin
    if (rx_we && byte_index == '0) begin
      hdr0 <= q_item.miso_byte;
    end
    if (rx_we && byte_index == CNT_W'(1)) begin
      hdr1 <= q_item.miso_byte;
    end
  end

  // Receive store: write on bus exchange, read on host pop
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[byte_index[RX_AW-1:0]] <= q_item.miso_byte;
    end
    if (q_take && q_item.act == ACT_POP) begin
      rx_rd <= rx_mem[read_index[RX_AW-1:0]];
    end
  end

  // Transmit store: write on load, read the next byte to shift out
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_fill[TX_AW-1:0]] <= q_item.tx_byte;
    end
    if (q_take) begin
      tx_rd <= tx_mem[byte_index_next[TX_AW-1:0]];
    end
  end

  // Hold result fields until taken
  always_ff @(posedge clk) begin
    if (q_take) begin
      status_r   <= status_c;
      rxv_r      <= rxv_c;
      rxl_r      <= rxl_c;
      mosi_sel_r <= mosi_sel_c;
      len_r      <= len_old_c ? rx_count : rx_count_next;
      sel_r      <= select_level_next;
      wake_r     <= wake_level_next;
      mvalid_r   <= (phase_next != PH_IDLE);
      stamp_r    <= latched_time_next;
    end
  end

  assign chip_select_n = sel_r;
  assign wake_n        = wake_r;
  assign mosi_valid    = mvalid_r;
  assign mosi_byte     = mosi_sel_r ? tx_rd : 8'd0;
  assign rx_valid      = rxv_r;
  assign rx_out        = rxv_r ? rx_rd : 8'd0;
  assign rx_last       = rxl_r;
  assign msg_length    = len_r;
  assign stamp_us      = stamp_r;
  assign status        = status_r;

endmodule

// File: src/sensor_hub_spi_transfer_engine.sv
// Top level of the sensor hub SPI transfer engine: front queue plus back engine.
// Depends on shspi_pkg, shspi_front and shspi_back.
//
//  channel  handshake              payload
//  -------  ---------------------  --------------------------------------------------
//  in       in_valid / in_ready    action, miso_byte, tx_byte, tx_last,
//                                  read_capacity, event_time_us
//  out      out_valid / out_ready  chip_select_n, wake_n, mosi_valid, mosi_byte,
//                                  rx_valid, rx_out, rx_last, msg_length, stamp_us, status
//  cfg      cfg_we                 cfg_wdata (link enable)
//
// One item per cycle sustained while the output is not stalled; an accepted item
// passes the queue and then the result register before its result is offered.
// The store reads sit beside the result register.
// Reset (rst, synchronous) idles the link; the stores need no clearing pass.
// A stalled output holds its result; the queue keeps accepting until it holds two items.
module sensor_hub_spi_transfer_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  miso_byte,
  input  logic [7:0]  tx_byte,
  input  logic        tx_last,
  input  logic [15:0] read_capacity,
  input  logic [31:0] event_time_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        chip_select_n,
  output logic        wake_n,
  output logic        mosi_valid,
  output logic [7:0]  mosi_byte,
  output logic        rx_valid,
  output logic [7:0]  rx_out,
  output logic        rx_last,
  output logic [9:0]  msg_length,
  output logic [31:0] stamp_us,
  output logic [2:0]  status
);
  import shspi_pkg::*;

  logic  q_valid;
  logic  q_take;
  item_t q_item;

  // Accept and classify
  shspi_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .miso_byte     (miso_byte),
    .tx_byte       (tx_byte),
    .tx_last       (tx_last),
    .read_capacity (read_capacity),
    .event_time_us (event_time_us),
    .q_valid       (q_valid),
    .q_take        (q_take),
    .q_item        (q_item)
  );

  // Execute and report
  shspi_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_valid       (q_valid),
    .q_take        (q_take),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .chip_select_n (chip_select_n),
    .wake_n        (wake_n),
    .mosi_valid    (mosi_valid),
    .mosi_byte     (mosi_byte),
    .rx_valid      (rx_valid),
    .rx_out        (rx_out),
    .rx_last       (rx_last),
    .msg_length    (msg_length),
    .stamp_us      (stamp_us),
    .status        (status)
  );

endmodule

// File: src/shspi_checker.sv
// Port-level checks for the sensor hub SPI transfer engine, bound to the top level.
// Depends on shspi_pkg for status codes and buffer size.
module shspi_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        chip_select_n,
  input logic        mosi_valid,
  input logic [7:0]  mosi_byte,
  input logic        rx_valid,
  input logic [7:0]  rx_out,
  input logic        rx_last,
  input logic [9:0]  msg_length,
  input logic [2:0]  status
);
  import shspi_pkg::*;

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(msg_length))
    else $error("result dropped or changed while stalled");

  // Chip select is low exactly while a transfer runs
  a_select_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> chip_select_n != mosi_valid)
    else $error("chip select disagrees with transfer activity");

  // Popped byte only with ok status; no stray last mark or data
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_valid |-> status == ST_OK)
    else $error("popped byte with error status");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rx_valid |-> rx_out == 8'd0 && !rx_last)
    else $error("rx fields set without a popped byte");

  // Reported length never exceeds the receive store; mosi byte is zero while idle
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> msg_length <= 10'(RX_BYTES) && (mosi_valid || mosi_byte == 8'd0))
    else $error("length out of range or mosi byte while idle");

endmodule

bind sensor_hub_spi_transfer_engine shspi_checker u_shspi_checker (.*);

// File: sim/shspi_link_checker.sv
// Checker for the sensor hub SPI transfer engine: watches both channels and the
// register port, predicts each result and compares it. Depends on shspi_pkg.
module shspi_link_checker
  import shspi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  miso_byte,
  input  logic [7:0]  tx_byte,
  input  logic        tx_last,
  input  logic [15:0] read_capacity,
  input  logic [31:0] event_time_us,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        chip_select_n,
  input  logic        wake_n,
  input  logic        mosi_valid,
  input  logic [7:0]  mosi_byte,
  input  logic        rx_valid,
  input  logic [7:0]  rx_out,
  input  logic        rx_last,
  input  logic [9:0]  msg_length,
  input  logic [31:0] stamp_us,
  input  logic [2:0]  status,
  output int          mismatches,
  output int          outstanding
);

  // One result item as seen on the output channel
  typedef struct packed {
    logic        cs_n;
    logic        wake_n;
    logic        busy;
    logic [7:0]  mosi;
    logic        rx_v;
    logic [7:0]  rx_b;
    logic        rx_l;
    logic [9:0]  len;
    logic [31:0] stamp;
    status_t     st;
  } link_view_t;

  // Predicted link state
  logic        link_en;
  phase_t      ph;
  logic        irq_pend;
  logic [7:0]  rx_mem [RX_BYTES];
  logic [9:0]  rx_cnt;
  logic [7:0]  tx_mem [TX_BYTES];
  logic [8:0]  tx_fill;
  logic [8:0]  tx_len;
  logic [9:0]  byte_idx;
  logic [9:0]  exp_len;
  logic [9:0]  rd_idx;
  logic [31:0] stamp;
  logic        sel_n;
  logic        wake_lvl;
  logic        tx_over;

  link_view_t  awaited_views [$];

  // Length word from the first two header bytes; bytes not yet received count as zero
  function automatic logic [9:0] header_len();
    logic [15:0] raw;
    raw = {(byte_idx > 1) ? rx_mem[1] : 8'h00, (byte_idx > 0) ? rx_mem[0] : 8'h00};
    raw = raw & ~LEN_FLAG;
    return (raw > RX_BYTES) ? 10'(RX_BYTES) : raw[9:0];
  endfunction

  // Start a transfer if idle, drained and an interrupt is waiting
  task automatic maybe_launch();
    if (ph != PH_IDLE || rx_cnt != 0 || !irq_pend) return;
    irq_pend = 1'b0;
    sel_n    = 1'b0;
    byte_idx = '0;
    if (tx_len != 0) begin
      ph       = PH_WRITE;
      exp_len  = 10'(tx_len);
      wake_lvl = 1'b1;
    end else begin
      ph      = PH_HDR;
      exp_len = 10'(HEADER_BYTES);
    end
  endtask

  // Close the current transfer, or move from header to body
  task automatic end_transfer();
    logic [9:0] len;
    len = header_len();
    case (ph)
      PH_HDR: begin
        if (len > HEADER_BYTES) begin
          ph      = PH_BODY;
          exp_len = len;
          return;
        end
        rx_cnt = '0;
      end
      PH_BODY: begin
        rx_cnt = len;
      end
      default: begin
        rx_cnt = (tx_len < len) ? 10'(tx_len) : len;
        tx_len = '0;
      end
    endcase
    sel_n  = 1'b1;
    ph     = PH_IDLE;
    rd_idx = '0;
    maybe_launch();
  endtask

  // Apply one input item and work out its result
  task automatic advance(input act_t a, input logic [7:0] mb, input logic [7:0] tb,
                         input logic tl, input logic [15:0] cap, input logic [31:0] t,
                         output link_view_t v);
    status_t    st;
    logic       rv;
    logic       rl;
    logic [7:0] rb;
    logic [9:0] len_out;
    logic       len_held;
    st       = ST_OK;
    rv       = 1'b0;
    rl       = 1'b0;
    rb       = 8'h00;
    len_out  = '0;
    len_held = 1'b0;
    case (a)
      ACT_IRQ: begin
        stamp    = t;
        irq_pend = 1'b1;
        maybe_launch();
      end
      ACT_LOAD: begin
        if (tx_len != 0) begin
          st = ST_BUSY;
        end else if (tx_over || tx_fill >= TX_BYTES) begin
          // drop bytes past the store; the last one discards the message
          st      = ST_BAD_PARAM;
          tx_over = !tl;
          if (tl) tx_fill = '0;
        end else begin
          tx_mem[tx_fill[TX_AW-1:0]] = tb;
          tx_fill++;
          if (tl) begin
            tx_len   = tx_fill;
            tx_fill  = '0;
            wake_lvl = 1'b0;
          end
        end
      end
      ACT_XFER: begin
        if (!link_en || ph == PH_IDLE) begin
          st = ST_IGNORED;
        end else begin
          if (byte_idx < RX_BYTES) rx_mem[byte_idx[RX_AW-1:0]] = mb;
          byte_idx++;
          if (byte_idx >= exp_len) end_transfer();
        end
      end
      ACT_POP: begin
        len_out  = rx_cnt;
        len_held = 1'b1;
        if (rx_cnt == 0) begin
          st = ST_NONE;
        end else if (rd_idx == 0 && cap < rx_cnt) begin
          // host buffer too small: drop the message
          st     = ST_BAD_PARAM;
          rx_cnt = '0;
          maybe_launch();
        end else begin
          rv = 1'b1;
          rb = rx_mem[rd_idx[RX_AW-1:0]];
          rd_idx++;
          if (rd_idx >= rx_cnt) begin
            rl     = 1'b1;
            rx_cnt = '0;
            rd_idx = '0;
            maybe_launch();
          end
        end
      end
    endcase
    v.cs_n   = sel_n;
    v.wake_n = wake_lvl;
    v.busy   = (ph != PH_IDLE);
    v.mosi   = (ph == PH_WRITE && byte_idx < TX_BYTES) ? tx_mem[byte_idx[TX_AW-1:0]] : 8'h00;
    v.rx_v   = rv;
    v.rx_b   = rb;
    v.rx_l   = rl;
    v.len    = len_held ? len_out : rx_cnt;
    v.stamp  = stamp;
    v.st     = st;
  endtask

  task automatic show(input string tag, input link_view_t v);
    $display("  %s: cs_n=%0b wake_n=%0b mosi_v=%0b mosi=%02h rx_v=%0b rx=%02h",
             tag, v.cs_n, v.wake_n, v.busy, v.mosi, v.rx_v, v.rx_b);
    $display("    rx_last=%0b len=%0d stamp=%08h status=%0d",
             v.rx_l, v.len, v.stamp, v.st);
  endtask

  // Compare results, then predict new items, then take register writes
  always @(posedge clk) begin : watch
    link_view_t want;
    link_view_t got;
    if (rst) begin
      link_en    = 1'b0;
      ph         = PH_IDLE;
      irq_pend   = 1'b0;
      rx_cnt     = '0;
      tx_fill    = '0;
      tx_len     = '0;
      byte_idx   = '0;
      exp_len    = '0;
      rd_idx     = '0;
      stamp      = '0;
      sel_n      = 1'b1;
      wake_lvl   = 1'b1;
      tx_over    = 1'b0;
      mismatches = 0;
      awaited_views.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.cs_n   = chip_select_n;
        got.wake_n = wake_n;
        got.busy   = mosi_valid;
        got.mosi   = mosi_byte;
        got.rx_v   = rx_valid;
        got.rx_b   = rx_out;
        got.rx_l   = rx_last;
        got.len    = msg_length;
        got.stamp  = stamp_us;
        got.st     = status_t'(status);
        if (awaited_views.size() == 0) begin
          if (mismatches < 10) begin
            $display("result with nothing awaited at %0t", $time);
            show("actual", got);
          end
          mismatches++;
        end else begin
          want = awaited_views.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("result mismatch at %0t", $time);
              show("expected", want);
              show("actual", got);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        advance(act_t'(action), miso_byte, tx_byte, tx_last, read_capacity,
                event_time_us, want);
        awaited_views.push_back(want);
      end
      if (cfg_we) link_en = cfg_wdata;
    end
    outstanding <= awaited_views.size();
  end

endmodule

// File: sim/sensor_hub_spi_transfer_engine_tb.sv
// Testbench top for the sensor hub SPI transfer engine: clock, reset, stimulus and verdict.
// Depends on shspi_pkg, the engine RTL and shspi_link_checker.
module sensor_hub_spi_transfer_engine_tb;
  import shspi_pkg::*;

  localparam int FEED_ITEMS  = 700;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic        cfg_wdata     = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [1:0]  action        = ACT_IRQ;
  logic [7:0]  miso_byte     = 8'h00;
  logic [7:0]  tx_byte       = 8'h00;
  logic        tx_last       = 1'b0;
  logic [15:0] read_capacity = 16'h0000;
  logic [31:0] event_time_us = 32'h0;
  logic        out_valid;
  logic        out_ready     = 1'b1;
  logic        chip_select_n;
  logic        wake_n;
  logic        mosi_valid;
  logic [7:0]  mosi_byte;
  logic        rx_valid;
  logic [7:0]  rx_out;
  logic        rx_last;
  logic [9:0]  msg_length;
  logic [31:0] stamp_us;
  logic [2:0]  status;
  int          mismatches;
  int          outstanding;

  bit          calm        = 1'b0;
  bit          link_on     = 1'b0;
  int          fed         = 0;
  int          hold_cnt    = 0;
  int          cycles      = 0;
  logic        seen_busy   = 1'b0;
  logic [9:0]  seen_len    = '0;
  logic        seen_wake_n = 1'b1;

  sensor_hub_spi_transfer_engine dut (.*);
  shspi_link_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the output side per item, except in calm stretches
  always @(posedge clk) begin : take_side
    int w;
    if (rst) begin
      out_ready <= 1'b1;
      hold_cnt  <= 0;
    end else if (out_ready && out_valid) begin
      w = calm ? 0 : $urandom_range(3, 0);
      hold_cnt  <= w;
      out_ready <= (w == 0);
    end else if (!out_ready) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= (hold_cnt == 1);
    end
  end

  // Keep the last result for resynchronizing the stimulus
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      seen_busy   <= mosi_valid;
      seen_len    <= msg_length;
      seen_wake_n <= wake_n;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sensor_hub_spi_transfer_engine_tb: errors");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until taken
  task automatic send(input act_t a, input logic [7:0] mb, input logic [7:0] tb,
                      input logic tl, input logic [15:0] cap, input logic [31:0] t);
    int gap;
    gap = calm ? 0 : $urandom_range(3, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= a;
    miso_byte     <= mb;
    tx_byte       <= tb;
    tx_last       <= tl;
    read_capacity <= cap;
    event_time_us <= t;
    do @(posedge clk); while (!in_ready);
    if (!(a == ACT_XFER && !link_on)) fed++;
  endtask

  task automatic send_any(input act_t a);
    send(a, 8'($urandom), 8'($urandom), 1'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic xfer(input logic [7:0] mb);
    send(ACT_XFER, mb, 8'($urandom), 1'($urandom), 16'($urandom), $urandom);
  endtask

  // Hold the input side until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_link(input bit on);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_we    <= 1'b0;
    link_on = on;
  endtask

  // Finish any transfer, empty the receive store and flush a waiting message
  task automatic settle();
    bit more;
    more = 1'b1;
    while (more) begin
      drain();
      if (link_on && seen_busy) xfer(8'h00);
      else if (seen_len != 0)
        send(ACT_POP, 8'($urandom), 8'($urandom), 1'($urandom), 16'hFFFF, $urandom);
      else if (link_on && !seen_wake_n) send_any(ACT_IRQ);
      else more = 1'b0;
    end
  endtask

  function automatic int frame_len(input logic [15:0] w);
    int l;
    l = int'(w & 16'h7FFF);
    return (l > RX_BYTES) ? RX_BYTES : l;
  endfunction

  function automatic logic [15:0] pick_cap(input int n);
    int r;
    r = $urandom_range(19, 0);
    if (r < 3 && n > 0) return 16'($urandom_range(n - 1, 0));
    if (r < 6) return 16'(n);
    if (r < 9) return 16'hFFFF;
    return 16'($urandom_range(65535, n));
  endfunction

  function automatic logic [15:0] pick_hdr();
    logic [15:0] w;
    int          r;
    r = $urandom_range(99, 0);
    if (r < 80) w = 16'($urandom_range(40, 5));
    else if (r < 88) w = 16'($urandom_range(4, 0));
    else if (r < 95) w = 16'($urandom_range(RX_BYTES, 41));
    else return 16'($urandom);
    w[15] = 1'($urandom_range(1, 0));
    return w;
  endfunction

  // Pop a whole message, or one item when the capacity falls short
  task automatic pop_msg(input int n);
    logic [15:0] cap;
    cap = pick_cap(n);
    repeat ((cap < n) ? 1 : n)
      send(ACT_POP, 8'($urandom), 8'($urandom), 1'($urandom), cap, $urandom);
  endtask

  // Header read, body read and pops; cut drops body bytes and skips the pops
  task automatic read_msg(input logic [15:0] hdr, input int cut);
    int len;
    int body;
    len = frame_len(hdr);
    send_any(ACT_IRQ);
    xfer(hdr[7:0]);
    xfer(hdr[15:8]);
    repeat (HEADER_BYTES - 2) xfer(8'($urandom));
    if (len > HEADER_BYTES) begin
      body = len - HEADER_BYTES;
      if (cut > body) cut = body;
      repeat (body - cut) xfer(8'($urandom));
      if (cut == 0) pop_msg(len);
    end
  endtask

  // Load a message, write it out and pop the captured reply
  task automatic write_msg(input int n, input logic [15:0] hdr);
    int len;
    for (int i = 0; i < n; i++)
      send(ACT_LOAD, 8'($urandom), 8'($urandom), i == n - 1, 16'($urandom), $urandom);
    send_any(ACT_IRQ);
    for (int i = 0; i < n; i++)
      xfer((i == 0) ? hdr[7:0] : ((i == 1) ? hdr[15:8] : 8'($urandom)));
    len = frame_len({(n > 1) ? hdr[15:8] : 8'h00, hdr[7:0]});
    if (len > n) len = n;
    if (len > 0) pop_msg(len);
  endtask

  initial begin : stimulus
    int          seqs;
    int          off_run;
    int          overflows;
    int          pick;
    int          n;
    int          r;
    bit          dirty;
    logic [15:0] w;
    seqs      = 0;
    off_run   = 0;
    overflows = 0;
    dirty     = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Link closed: empty pop, ignored exchange
    send(ACT_POP, 8'h00, 8'h00, 1'b0, 16'h0000, 32'h0);
    send(ACT_XFER, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    set_link(1'b1);
    // Exchange while idle, one-byte message, load while committed
    send(ACT_XFER, 8'h00, 8'h00, 1'b0, 16'h0000, 32'h0);
    send(ACT_LOAD, 8'h00, 8'hA5, 1'b1, 16'h0000, 32'h0);
    send(ACT_LOAD, 8'hFF, 8'h5A, 1'b0, 16'hFFFF, 32'h0);
    send(ACT_IRQ, 8'h00, 8'h00, 1'b0, 16'h0000, 32'hFFFF_FFFF);
    // Reply with only header byte 0, then a host buffer too small
    send(ACT_XFER, 8'h05, 8'h00, 1'b0, 16'h0000, 32'h0);
    send(ACT_POP, 8'h00, 8'h00, 1'b0, 16'h0000, 32'h0);
    // Short header ends the read with no message
    send(ACT_IRQ, 8'h00, 8'h00, 1'b0, 16'h0000, 32'h0);
    xfer(8'h04);
    xfer(8'h00);
    xfer(8'hFF);
    xfer(8'hFF);
    // Length flag masked off, short body, pops
    read_msg(16'h8008, 0);

    settle();
    fed = 0;
    while (fed < FEED_ITEMS) begin
      calm <= ($urandom_range(4, 0) == 0);
      if (dirty || $urandom_range(2, 0) == 0) settle();
      // Close the link now and then for a short phase
      if (!link_on && off_run >= 2) begin
        set_link(1'b1);
      end else if (link_on && seqs % 15 == 14) begin
        set_link(1'b0);
        off_run = 0;
      end
      if (!link_on) off_run++;
      dirty = 1'b0;
      pick  = $urandom_range(99, 0);
      if (pick < 40) begin
        read_msg(pick_hdr(), 0);
      end else if (pick < 62) begin
        n = $urandom_range(12, 1);
        r = $urandom_range(9, 0);
        if (r < 5) w = 16'(n);
        else if (r < 8) w = 16'($urandom_range(40, 0));
        else w = 16'($urandom);
        write_msg(n, w);
      end else if (pick < 65) begin
        write_msg($urandom_range(200, 13), 16'($urandom));
      end else if (pick < 77) begin
        repeat ($urandom_range(6, 1)) send_any(act_t'($urandom_range(3, 0)));
        dirty = 1'b1;
      end else if (pick < 88) begin
        read_msg(pick_hdr(), $urandom_range(3, 1));
        dirty = 1'b1;
      end else if (pick < 95 || overflows >= 2) begin
        // Extra interrupt leaves one waiting behind the read
        send_any(ACT_IRQ);
        read_msg(pick_hdr(), 0);
        dirty = 1'b1;
      end else begin
        // Message longer than the transmit store
        n = TX_BYTES + $urandom_range(4, 1);
        for (int i = 0; i < n; i++)
          send(ACT_LOAD, 8'($urandom), 8'($urandom), i == n - 1, 16'($urandom), $urandom);
        overflows++;
        dirty = 1'b1;
      end
      seqs++;
    end

    calm <= 1'b0;
    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sensor_hub_spi_transfer_engine_tb: clean");
    end else begin
      $display("sensor_hub_spi_transfer_engine_tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/shspi_pkg.sv
src/shspi_front.sv
src/shspi_back.sv
src/sensor_hub_spi_transfer_engine.sv
src/shspi_checker.sv
sim/shspi_link_checker.sv
sim/sensor_hub_spi_transfer_engine_tb.sv
